>>> design/cau_pkg.sv
// Shared types for the complex arithmetic unit: opcodes and the control
// word that travels down the pipeline next to the data. No dependencies.
package cau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic vld;
		op_t  op;
		logic dz;
		logic neg_re;
		logic neg_im;
	} ctl_t;

endpackage

>>> design/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply or divide two complex
// signed fixed-point operands (WIDTH bits, FRAC_BITS fraction bits). One beat
// is accepted every cycle while in_ready is high. Each result passes through
// WIDTH+4 register stages: one multiply stage, one combine stage, a chain of
// WIDTH+1 restoring divider cells (one quotient bit each; the top bit lets the
// output stage flag overflow) and the output register. Every op travels the
// full chain, so results leave in order.
// Stalls ripple back stage by stage, so bubbles are squeezed out and in_ready
// is high whenever the output slot is free.
// Products are truncated toward zero, divide uses a*conj(b)/|b|^2 truncated
// toward zero, both parts saturate and raise overflowed; a zero divisor gives
// zero results with div_zero set.
module complex_arithmetic_unit #(
	parameter int WIDTH     = 16,
	parameter int FRAC_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              op,
	input  logic signed [WIDTH-1:0] a_re,
	input  logic signed [WIDTH-1:0] a_im,
	input  logic signed [WIDTH-1:0] b_re,
	input  logic signed [WIDTH-1:0] b_im,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [WIDTH-1:0] res_re,
	output logic signed [WIDTH-1:0] res_im,
	output logic                    overflowed,
	output logic                    div_zero
);

	// remainder lane width: holds |num|<<FRAC_BITS and den<<WIDTH
	localparam int RW = 3 * WIDTH + FRAC_BITS + 2;
	localparam int NC = WIDTH + 1;	// divider cells

	logic            en1, en2, en_out;
	logic            s1_vld;
	logic            en_c   [0:NC];
	cau_pkg::ctl_t   ctl_c  [0:NC];
	logic [RW-1:0]   rre_c  [0:NC];
	logic [RW-1:0]   rim_c  [0:NC];
	logic [WIDTH:0]  qre_c  [0:NC];
	logic [WIDTH:0]  qim_c  [0:NC];
	logic [2*WIDTH-1:0] den_c [0:NC];

	// stall chain: a stage loads when empty or when the next one moves
	assign en_out    = !out_valid || out_ready;
	assign en_c[NC]  = en_out;
	assign en2       = !ctl_c[0].vld || en_c[0];
	assign en1       = !s1_vld || en2;
	assign in_ready  = en1;

	cau_front #(.W(WIDTH), .F(FRAC_BITS), .RW(RW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en1       (en1),
		.en2       (en2),
		.in_valid  (in_valid),
		.op        (op),
		.a_re      (a_re),
		.a_im      (a_im),
		.b_re      (b_re),
		.b_im      (b_im),
		.s1_vld    (s1_vld),
		.ctl_s2    (ctl_c[0]),
		.rem_re_s2 (rre_c[0]),
		.rem_im_s2 (rim_c[0]),
		.den_s2    (den_c[0])
	);

	assign qre_c[0] = '0;
	assign qim_c[0] = '0;

	// cell j settles quotient bit WIDTH-j
	for (genvar j = 0; j < NC; j++) begin : g_cell
		assign en_c[j] = !ctl_c[j+1].vld || en_c[j+1];

		cau_div_cell #(.W(WIDTH), .RW(RW), .K(WIDTH - j)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en_c[j]),
			.ctl_i    (ctl_c[j]),
			.rem_re_i (rre_c[j]),
			.rem_im_i (rim_c[j]),
			.q_re_i   (qre_c[j]),
			.q_im_i   (qim_c[j]),
			.den_i    (den_c[j]),
			.ctl_q    (ctl_c[j+1]),
			.rem_re_q (rre_c[j+1]),
			.rem_im_q (rim_c[j+1]),
			.q_re_q   (qre_c[j+1]),
			.q_im_q   (qim_c[j+1]),
			.den_q    (den_c[j+1])
		);
	end

	cau_out #(.W(WIDTH), .RW(RW)) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en_out),
		.ctl_i      (ctl_c[NC]),
		.rem_re_i   (rre_c[NC]),
		.rem_im_i   (rim_c[NC]),
		.q_re_i     (qre_c[NC]),
		.q_im_i     (qim_c[NC]),
		.out_valid  (out_valid),
		.res_re     (res_re),
		.res_im     (res_im),
		.overflowed (overflowed),
		.div_zero   (div_zero)
	);

endmodule

>>> design/cau_front.sv
// Front end: products and add/sub (stage 1), then sums, sign/magnitude split
// and operand alignment for the divider chain (stage 2). Uses cau_pkg.
module cau_front #(
	parameter int W  = 16,
	parameter int F  = 8,
	parameter int RW = 58
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en1,
	input  logic                       en2,
	input  logic                       in_valid,
	input  logic [1:0]                 op,
	input  logic signed [W-1:0]        a_re,
	input  logic signed [W-1:0]        a_im,
	input  logic signed [W-1:0]        b_re,
	input  logic signed [W-1:0]        b_im,
	output logic                       s1_vld,
	output cau_pkg::ctl_t              ctl_s2,
	output logic [RW-1:0]              rem_re_s2,
	output logic [RW-1:0]              rem_im_s2,
	output logic [2*W-1:0]             den_s2
);

	logic                    vld_s1;
	cau_pkg::op_t            op_s1;
	logic                    dz_s1;
	logic signed [2*W-1:0]   prr_s1, pii_s1, pir_s1, pri_s1, srr_s1, sii_s1;
	logic signed [W:0]       sre_s1, sim_s1;

	logic signed [W:0]       sre, sim;
	logic signed [2*W:0]     sum_re, sum_im;
	logic [2*W:0]            mag_re, mag_im;
	logic [RW-1:0]           rem_re, rem_im;

	always_comb begin
		if (cau_pkg::op_t'(op) == cau_pkg::OP_SUB) begin
			sre = {a_re[W-1], a_re} - {b_re[W-1], b_re};
			sim = {a_im[W-1], a_im} - {b_im[W-1], b_im};
		end else begin
			sre = {a_re[W-1], a_re} + {b_re[W-1], b_re};
			sim = {a_im[W-1], a_im} + {b_im[W-1], b_im};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1  <= cau_pkg::op_t'(op);
			dz_s1  <= (cau_pkg::op_t'(op) == cau_pkg::OP_DIV) && (b_re == '0) && (b_im == '0);
			prr_s1 <= a_re * b_re;
			pii_s1 <= a_im * b_im;
			pir_s1 <= a_im * b_re;
			pri_s1 <= a_re * b_im;
			srr_s1 <= b_re * b_re;
			sii_s1 <= b_im * b_im;
			sre_s1 <= sre;
			sim_s1 <= sim;
		end
	end

	assign s1_vld = vld_s1;

	// stage 2: combine products, split sign and magnitude
	always_comb begin
		case (op_s1)
			cau_pkg::OP_MUL: begin
				sum_re = {prr_s1[2*W-1], prr_s1} - {pii_s1[2*W-1], pii_s1};
				sum_im = {pir_s1[2*W-1], pir_s1} + {pri_s1[2*W-1], pri_s1};
			end
			cau_pkg::OP_DIV: begin
				sum_re = {prr_s1[2*W-1], prr_s1} + {pii_s1[2*W-1], pii_s1};
				sum_im = {pir_s1[2*W-1], pir_s1} - {pri_s1[2*W-1], pri_s1};
			end
			default: begin
				sum_re = {{W{sre_s1[W]}}, sre_s1};
				sum_im = {{W{sim_s1[W]}}, sim_s1};
			end
		endcase
		mag_re = sum_re[2*W] ? $unsigned(-sum_re) : $unsigned(sum_re);
		mag_im = sum_im[2*W] ? $unsigned(-sum_im) : $unsigned(sum_im);
		rem_re = RW'(mag_re);
		rem_im = RW'(mag_im);
		case (op_s1)
			cau_pkg::OP_MUL: begin
				rem_re = rem_re >> F;
				rem_im = rem_im >> F;
			end
			cau_pkg::OP_DIV: begin
				rem_re = rem_re << F;
				rem_im = rem_im << F;
			end
			default: begin
				rem_re = rem_re;
				rem_im = rem_im;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en2) begin
			ctl_s2.vld    <= vld_s1;
			ctl_s2.op     <= op_s1;
			ctl_s2.dz     <= dz_s1;
			ctl_s2.neg_re <= sum_re[2*W];
			ctl_s2.neg_im <= sum_im[2*W];
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			rem_re_s2 <= rem_re;
			rem_im_s2 <= rem_im;
			den_s2    <= $unsigned(srr_s1) + $unsigned(sii_s1);
		end
	end

endmodule

>>> design/cau_div_cell.sv
// One restoring-division cell: settles quotient bit K for both lanes and
// hands remainder, quotient and sideband on. Uses cau_pkg.
module cau_div_cell #(
	parameter int W  = 16,
	parameter int RW = 58,
	parameter int K  = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  cau_pkg::ctl_t    ctl_i,
	input  logic [RW-1:0]    rem_re_i,
	input  logic [RW-1:0]    rem_im_i,
	input  logic [W:0]       q_re_i,
	input  logic [W:0]       q_im_i,
	input  logic [2*W-1:0]   den_i,
	output cau_pkg::ctl_t    ctl_q,
	output logic [RW-1:0]    rem_re_q,
	output logic [RW-1:0]    rem_im_q,
	output logic [W:0]       q_re_q,
	output logic [W:0]       q_im_q,
	output logic [2*W-1:0]   den_q
);

	logic [RW-1:0] dsh;
	logic          is_div, ge_re, ge_im;
	logic [RW-1:0] rem_re_n, rem_im_n;
	logic [W:0]    q_re_n, q_im_n;

	always_comb begin
		dsh      = RW'(den_i) << K;
		is_div   = (ctl_i.op == cau_pkg::OP_DIV);
		ge_re    = is_div && (rem_re_i >= dsh);
		ge_im    = is_div && (rem_im_i >= dsh);
		rem_re_n = ge_re ? rem_re_i - dsh : rem_re_i;
		rem_im_n = ge_im ? rem_im_i - dsh : rem_im_i;
		q_re_n   = q_re_i;
		q_im_n   = q_im_i;
		q_re_n[K] = ge_re;
		q_im_n[K] = ge_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_re_q <= rem_re_n;
			rem_im_q <= rem_im_n;
			q_re_q   <= q_re_n;
			q_im_q   <= q_im_n;
			den_q    <= den_i;
		end
	end

endmodule

>>> design/cau_out.sv
// Output stage: picks quotient or passed-through magnitude, applies sign,
// saturates and holds the result beat. Uses cau_pkg.
module cau_out #(
	parameter int W  = 16,
	parameter int RW = 58
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  cau_pkg::ctl_t       ctl_i,
	input  logic [RW-1:0]       rem_re_i,
	input  logic [RW-1:0]       rem_im_i,
	input  logic [W:0]          q_re_i,
	input  logic [W:0]          q_im_i,
	output logic                out_valid,
	output logic signed [W-1:0] res_re,
	output logic signed [W-1:0] res_im,
	output logic                overflowed,
	output logic                div_zero
);

	localparam logic [RW-1:0] LIM = RW'(1) << (W-1);

	logic [RW-1:0] mag_re, mag_im;
	logic [W:0]    sat_re, sat_im;

	// returns {saturated, value}
	function automatic logic [W:0] clamp(input logic neg, input logic [RW-1:0] mag);
		logic [W:0] r;
		if (neg) begin
			if (mag > LIM) r = {1'b1, 1'b1, {(W-1){1'b0}}};
			else           r = {1'b0, W'(RW'(0) - mag)};
		end else begin
			if (mag > LIM - RW'(1)) r = {1'b1, 1'b0, {(W-1){1'b1}}};
			else                    r = {1'b0, mag[W-1:0]};
		end
		return r;
	endfunction

	always_comb begin
		if (ctl_i.op == cau_pkg::OP_DIV) begin
			mag_re = RW'(q_re_i);
			mag_im = RW'(q_im_i);
		end else begin
			mag_re = rem_re_i;
			mag_im = rem_im_i;
		end
		sat_re = clamp(ctl_i.neg_re, mag_re);
		sat_im = clamp(ctl_i.neg_im, mag_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctl_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_i.dz) begin
				res_re     <= '0;
				res_im     <= '0;
				overflowed <= 1'b0;
			end else begin
				res_re     <= sat_re[W-1:0];
				res_im     <= sat_im[W-1:0];
				overflowed <= sat_re[W] | sat_im[W];
			end
			div_zero <= ctl_i.dz;
		end
	end

endmodule

>>> design/cau_checker.sv
// Port-level checks for complex_arithmetic_unit and the bind that attaches
// them. Depends only on the top level's ports.
module cau_checker #(
	parameter int WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [WIDTH-1:0] res_re,
	input logic signed [WIDTH-1:0] res_im,
	input logic                    overflowed,
	input logic                    div_zero
);

	localparam logic signed [WIDTH-1:0] SMAX = {1'b0, {(WIDTH-1){1'b1}}};
	localparam logic signed [WIDTH-1:0] SMIN = {1'b1, {(WIDTH-1){1'b0}}};

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(res_re) && $stable(res_im))
		else $error("result beat changed while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output slot");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_zero |-> res_re == '0 && res_im == '0 && !overflowed)
		else $error("divide by zero beat not cleared");

	a_ovf_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflowed |->
			res_re == SMAX || res_re == SMIN || res_im == SMAX || res_im == SMIN)
		else $error("overflow flagged without a clamped part");

endmodule

bind complex_arithmetic_unit cau_checker #(.WIDTH(WIDTH)) u_cau_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.res_re     (res_re),
	.res_im     (res_im),
	.overflowed (overflowed),
	.div_zero   (div_zero)
);

>>> bench/cau_checker.sv
// Scoreboard for the complex arithmetic unit: watches both channels, predicts
// each result from the input beat and compares. Depends on cau_pkg.
`timescale 1ns / 100ps
module cau_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [15:0] a_re,
	input  logic signed [15:0] a_im,
	input  logic signed [15:0] b_re,
	input  logic signed [15:0] b_im,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] res_re,
	input  logic signed [15:0] res_im,
	input  logic               overflowed,
	input  logic               div_zero,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               ovf;
		logic               dz;
	} cres_t;

	cres_t expected_q[$];

	// clamp an exact value to 16 bits
	function automatic logic signed [15:0] clamp16(longint v, inout logic ovf);
		if (v > 32767) begin
			ovf = 1'b1;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			ovf = 1'b1;
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// truncating divide of num*256 by den, magnitude capped past the range
	function automatic longint qdiv(longint num, longint den);
		longint m;
		longint q;
		m = (num < 0) ? -num : num;
		if (m / den > 128)
			q = 32769;
		else
			q = (m * 256) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic cres_t compute_result(cau_pkg::op_t o, longint ar, longint ai,
			longint br, longint bi);
		cres_t r;
		longint pre;
		longint pim;
		longint den;
		logic ovf;
		ovf = 1'b0;
		r.dz = 1'b0;
		case (o)
			cau_pkg::OP_ADD: begin
				pre = ar + br;
				pim = ai + bi;
			end
			cau_pkg::OP_SUB: begin
				pre = ar - br;
				pim = ai - bi;
			end
			cau_pkg::OP_MUL: begin
				// '/' truncates toward zero, same as shifting the magnitude
				pre = (ar * br - ai * bi) / 256;
				pim = (ai * br + ar * bi) / 256;
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.dz = 1'b1;
					pre = 0;
					pim = 0;
				end else begin
					pre = qdiv(ar * br + ai * bi, den);
					pim = qdiv(ai * br - ar * bi, den);
				end
			end
		endcase
		r.re = clamp16(pre, ovf);
		r.im = clamp16(pim, ovf);
		r.ovf = ovf;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cres_t e;
		if (!arst_n) begin
			errors <= 0;
			pending <= expected_q.size();
		end else begin
			if (in_valid && in_ready)
				expected_q.push_back(compute_result(cau_pkg::op_t'(op), a_re, a_im,
					b_re, b_im));
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					if (errors < 10)
						$display("cau_scoreboard: unexpected result %0d %0d",
							res_re, res_im);
					errors <= errors + 1;
				end else begin
					e = expected_q.pop_front();
					if (res_re !== e.re || res_im !== e.im || overflowed !== e.ovf ||
							div_zero !== e.dz) begin
						if (errors < 10)
							$display("cau_scoreboard: exp %0d %0d ovf%0b dz%0b got %0d %0d ovf%0b dz%0b",
								e.re, e.im, e.ovf, e.dz, res_re, res_im, overflowed, div_zero);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule

>>> bench/tb_top.sv
// Top of the complex arithmetic unit bench: clock, reset, beat stimulus and
// verdict. Depends on cau_pkg, complex_arithmetic_unit and cau_scoreboard.
`timescale 1ns / 100ps
module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = cau_pkg::OP_ADD;
	logic signed [15:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] res_re, res_im;
	logic overflowed, div_zero;
	int errors, pending;
	bit calm = 1'b0;       // no idling on either side
	bit hold_off = 1'b0;   // long receiver stall

	always #4 clk = ~clk;

	complex_arithmetic_unit dut (.*);

	cau_scoreboard chk (.*);

	// receiver: random stalls, long hold-off on request
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !hold_off && (calm || $urandom_range(99) >= 8);
	end

	// one beat: valid held until accepted, then optionally dropped while idling
	task automatic send(cau_pkg::op_t o, logic [15:0] ar, logic [15:0] ai,
			logic [15:0] br, logic [15:0] bi);
		in_valid <= 1'b1;
		op <= o;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		do @(posedge clk); while (!in_ready);
		if (!calm && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_val();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return '0;
			3: return 16'($urandom_range(511)) - 16'd256;  // small, near unity
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] corner[6];
		corner = '{16'h8000, 16'h7fff, 16'h0000, 16'h0100, 16'hff00, 16'h0001};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: field extremes per op, zero divisor, overflow cases
		for (int o = 0; o < 4; o++) begin
			send(cau_pkg::op_t'(o), 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
			send(cau_pkg::op_t'(o), 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
			send(cau_pkg::op_t'(o), 16'h0100, 16'hff00, 16'h0100, 16'h0001);
		end
		send(cau_pkg::OP_DIV, 16'h1234, 16'hedcb, 16'h0000, 16'h0000);
		send(cau_pkg::OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
		send(cau_pkg::OP_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h8000);
		send(cau_pkg::OP_MUL, 16'h8000, 16'h0000, 16'h8000, 16'h0000);
		for (int k = 0; k < 6; k++)
			send(cau_pkg::op_t'(k % 4), corner[k], corner[5 - k], corner[(k + 2) % 6],
				corner[(k + 3) % 6]);
		// sender pauses until every result is back
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		// long receiver stall while offering beats: pipe fills, input stalls
		fork
			begin
				hold_off = 1'b1;
				repeat (60) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int k = 0; k < 40; k++)
				send(cau_pkg::op_t'($urandom_range(3)), pick_val(), pick_val(),
					pick_val(), pick_val());
		join
		for (int k = 0; k < 460; k++) begin
			calm = (k >= 150 && k < 250);
			send(cau_pkg::op_t'($urandom_range(3)), pick_val(), pick_val(),
				pick_val(), pick_val());
		end
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb_top: done, errors");
		$finish;
	end
endmodule

>>> sim.f
design/cau_pkg.sv
design/cau_front.sv
design/cau_div_cell.sv
design/cau_out.sv
design/complex_arithmetic_unit.sv
design/cau_checker.sv
bench/cau_checker.sv
bench/tb_top.sv
